FILE: rtl/psdc_pkg.sv
// Shared constants, register indexes and fixed-point helpers for the slew-limited PID controller.
`timescale 1ns / 1ps

package psdc_pkg;

    localparam int VAL_W  = 32;
    localparam int GAIN_W = 31;
    localparam int WIDE_W = VAL_W + 8;
    localparam int PROD_W = VAL_W + GAIN_W;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = 3;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_MAX - WIDE_W'(1);

    localparam logic [VAL_W-1:0] SETTLE_ERR = VAL_W'(32768);
    localparam logic [VAL_W-1:0] SETTLE_DER = VAL_W'(6554);

    localparam logic [IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_SLEW_STEP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED  = 3'd5;
    localparam logic [IDX_W-1:0] REG_INTEG_BAND = 3'd6;
    localparam logic [IDX_W-1:0] REG_MODE       = 3'd7;

    localparam logic MODE_DRIVE = 1'b0;

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = GAIN_W'(393216);
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = GAIN_W'(66);
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = GAIN_W'(131072);
    localparam logic [GAIN_W-1:0] RST_SLEW_STEP  = GAIN_W'(524288);
    localparam logic [GAIN_W-1:0] RST_MAX_SPEED  = GAIN_W'(5242880);
    localparam logic [GAIN_W-1:0] RST_INTEG_BAND = GAIN_W'(262144);

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [GAIN_W-1:0]        t_gain;
    typedef logic [PROD_W-1:0]        t_prod;

    function automatic t_val sat_val(input t_wide v);
        t_val res;
        if (v > WIDE_MAX) begin
            res = VAL_W'(WIDE_MAX);
        end else if (v < WIDE_MIN) begin
            res = VAL_W'(WIDE_MIN);
        end else begin
            res = VAL_W'(v);
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] mag_val(input t_val v);
        logic [VAL_W-1:0] res;
        if (v[VAL_W-1]) begin
            res = (~VAL_W'(v)) + VAL_W'(1);
        end else begin
            res = VAL_W'(v);
        end
        return res;
    endfunction

    function automatic t_wide gain_wide(input t_gain g);
        t_wide res;
        res = $signed({{(WIDE_W - GAIN_W){1'b0}}, g});
        return res;
    endfunction

    // Scales a product magnitude back to Q16.16 and saturates it with the sign of the value.
    function automatic t_val q_finish(input t_prod prod, input logic neg);
        logic [PROD_W-FRAC_W-1:0] shifted;
        t_val                     res;
        shifted = prod[PROD_W-1:FRAC_W];
        if (shifted[PROD_W-FRAC_W-1:VAL_W-1] != '0) begin
            res = neg ? VAL_W'(WIDE_MIN) : VAL_W'(WIDE_MAX);
        end else if (neg) begin
            res = -$signed({1'b0, shifted[VAL_W-2:0]});
        end else begin
            res = $signed({1'b0, shifted[VAL_W-2:0]});
        end
        return res;
    endfunction

endpackage

FILE: rtl/pid_slew_drive_controller.sv
// Top level of the slew-limited PID drive controller: configuration, pipeline and stream ports.
`timescale 1ns / 1ps

// The controller takes one tick per transfer and returns one result transfer per tick. It is a
// three-register pipeline (input, product, result): a tick's result is registered in the input,
// product and result registers in turn, and a new tick can be taken in every cycle unless the
// output is stalled by m_axis_tready, since the integral and the previous error are updated as
// a tick leaves the input register and the applied power as it leaves the product register.
// The three gain multipliers sit between the input and product registers. Configuration writes
// take effect at once and must be made while no tick is in flight.
module pid_slew_drive_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [psdc_pkg::IDX_W-1:0]  i_cfg_addr,
    input  logic [psdc_pkg::VAL_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,   // measured [31:0], heading_deg [63:32]
    input  logic [0:0]                  s_axis_tuser,   // start_req [0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,   // left_drive [31:0], right_drive [63:32]
    output logic [0:0]                  m_axis_tuser    // settled [0]
);
    import psdc_pkg::*;

    t_val  r_target;
    t_gain r_prop_gain, r_integ_gain, r_deriv_gain, r_slew_step, r_max_speed, r_integ_band;
    logic  r_mode;

    t_val  r_integ, r_prev, r_power;
    t_val  n_integ, n_power;

    logic  r_v0, r_v1, r_vo;
    logic  adv_o, ready1, mv0, mv1;

    logic  r_s0_start;
    t_val  r_s0_meas, r_s0_head;

    logic  r_s1_start, r_s1_settled;
    logic  r_s1_neg_p, r_s1_neg_i, r_s1_neg_d;
    t_prod r_s1_prod_p, r_s1_prod_i, r_s1_prod_d;
    t_wide r_s1_corr;

    t_val  r_left, r_right;
    logic  r_settled;
    t_val  n_left, n_right;

    t_val             err, der, prev_eff, integ_eff;
    logic [VAL_W-1:0] err_mag, der_mag, integ_mag;
    logic             sign_flip;
    t_wide            head_w, head5, corr;

    t_val             q_p, q_i, q_d, tp, ap0, ap2;
    t_wide            hi, lo, ap1, lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_prop_gain  <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEG_GAIN;
            r_deriv_gain <= RST_DERIV_GAIN;
            r_slew_step  <= RST_SLEW_STEP;
            r_max_speed  <= RST_MAX_SPEED;
            r_integ_band <= RST_INTEG_BAND;
            r_mode       <= MODE_DRIVE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TARGET:     r_target     <= $signed(i_cfg_data);
                REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                REG_SLEW_STEP:  r_slew_step  <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_SPEED:  r_max_speed  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_BAND: r_integ_band <= i_cfg_data[GAIN_W-1:0];
                REG_MODE:       r_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign adv_o         = !r_vo || m_axis_tready;
    assign ready1        = !r_v1 || adv_o;
    assign mv1           = r_v1 && adv_o;
    assign mv0           = r_v0 && ready1;
    assign s_axis_tready = !r_v0 || ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_v0 <= s_axis_tvalid;
            end
            if (ready1) begin
                r_v1 <= r_v0;
            end
            if (adv_o) begin
                r_vo <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s0_start <= s_axis_tuser[0];
            r_s0_meas  <= $signed(s_axis_tdata[31:0]);
            r_s0_head  <= $signed(s_axis_tdata[63:32]);
        end
    end

    always_comb begin
        prev_eff  = r_s0_start ? '0 : r_prev;
        integ_eff = r_s0_start ? '0 : r_integ;
        err       = sat_val(WIDE_W'(r_target) - WIDE_W'(r_s0_meas));
        err_mag   = mag_val(err);
        if (err_mag < VAL_W'(r_integ_band)) begin
            n_integ = sat_val(WIDE_W'(integ_eff) + WIDE_W'(err));
        end else begin
            n_integ = '0;
        end
        sign_flip = (!err[VAL_W-1] && (err != '0) && prev_eff[VAL_W-1])
                 || (err[VAL_W-1] && !prev_eff[VAL_W-1] && (prev_eff != '0));
        if (r_mode == MODE_DRIVE && sign_flip) begin
            n_integ = '0;
        end
        integ_mag = mag_val(n_integ);
        der       = sat_val(WIDE_W'(err) - WIDE_W'(prev_eff));
        der_mag   = mag_val(der);
        head_w    = WIDE_W'(r_s0_head);
        head5     = -(head_w + (head_w <<< 2));
        corr      = head5[WIDE_W-1] ? ((head5 + WIDE_W'(1)) >>> 1) : (head5 >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (mv0) begin
            r_integ <= n_integ;
            r_prev  <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv0) begin
            r_s1_start   <= r_s0_start;
            r_s1_settled <= (err_mag < SETTLE_ERR) && (der_mag < SETTLE_DER);
            r_s1_neg_p   <= err[VAL_W-1];
            r_s1_neg_i   <= n_integ[VAL_W-1];
            r_s1_neg_d   <= der[VAL_W-1];
            r_s1_prod_p  <= PROD_W'(err_mag) * PROD_W'(r_prop_gain);
            r_s1_prod_i  <= PROD_W'(integ_mag) * PROD_W'(r_integ_gain);
            r_s1_prod_d  <= PROD_W'(der_mag) * PROD_W'(r_deriv_gain);
            r_s1_corr    <= corr;
        end
    end

    always_comb begin
        q_p = q_finish(r_s1_prod_p, r_s1_neg_p);
        q_i = q_finish(r_s1_prod_i, r_s1_neg_i);
        q_d = q_finish(r_s1_prod_d, r_s1_neg_d);
        tp  = sat_val(WIDE_W'(q_p) + WIDE_W'(q_i) + WIDE_W'(q_d));
        ap0 = r_s1_start ? '0 : r_power;
        hi  = WIDE_W'(ap0) + gain_wide(r_slew_step);
        lo  = WIDE_W'(ap0) - gain_wide(r_slew_step);
        if (WIDE_W'(tp) > hi) begin
            ap1 = hi;
        end else if (WIDE_W'(tp) < lo) begin
            ap1 = lo;
        end else begin
            ap1 = WIDE_W'(tp);
        end
        ap2 = sat_val(ap1);
        lim = gain_wide(r_max_speed);
        if (WIDE_W'(ap2) > lim) begin
            n_power = VAL_W'(lim);
        end else if (WIDE_W'(ap2) < -lim) begin
            n_power = VAL_W'(-lim);
        end else begin
            n_power = ap2;
        end
        if (r_mode == MODE_DRIVE) begin
            n_left  = sat_val(WIDE_W'(n_power) + r_s1_corr);
            n_right = sat_val(WIDE_W'(n_power) - r_s1_corr);
        end else begin
            n_left  = n_power;
            n_right = sat_val(-WIDE_W'(n_power));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= '0;
        end else if (mv1) begin
            r_power <= n_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_left    <= n_left;
            r_right   <= n_right;
            r_settled <= r_s1_settled;
        end
    end

    assign m_axis_tvalid   = r_vo;
    assign m_axis_tdata    = {r_right, r_left};
    assign m_axis_tuser[0] = r_settled;

endmodule

FILE: tb/drive_cmd_checker.sv
// Watches the tick and command streams of the drive controller, predicts each command and compares.
`timescale 1ns / 1ps

module drive_cmd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [psdc_pkg::IDX_W-1:0]  i_cfg_addr,
    input  logic [psdc_pkg::VAL_W-1:0]  i_cfg_data,
    input  logic                        i_tick_valid,
    input  logic                        i_tick_ready,
    input  logic [63:0]                 i_tick_data,    // measured [31:0], heading_deg [63:32]
    input  logic [0:0]                  i_tick_user,    // start_req [0]
    input  logic                        i_cmd_valid,
    input  logic                        i_cmd_ready,
    input  logic [63:0]                 i_cmd_data,     // left_drive [31:0], right_drive [63:32]
    input  logic [0:0]                  i_cmd_user,     // settled [0]
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_cmd_count,
    output int                          o_settled_count
);

    import psdc_pkg::*;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic               settled;
    } t_drive_cmd;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -Q_MAX - 64'sd1;

    t_drive_cmd expected_cmds[$];

    t_val   set_point;
    t_gain  kp, ki, kd, slew_lim, speed_lim, band;
    logic   mode_sel;
    longint integ_acc, last_err, power;

    function automatic longint sat_q(input longint v);
        longint r;
        r = v;
        if (v > Q_MAX) begin
            r = Q_MAX;
        end else if (v < Q_MIN) begin
            r = Q_MIN;
        end
        return r;
    endfunction

    function automatic longint abs_q(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Exact product of magnitudes, truncated toward zero, then saturated with the sign restored.
    function automatic longint gain_mul(input longint a, input t_gain g);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = abs_q(a);
        prod = (mag * {33'd0, g}) >> 16;
        if (prod > 64'(Q_MAX)) begin
            return (a < 0) ? Q_MIN : Q_MAX;
        end
        return (a < 0) ? -$signed(prod) : $signed(prod);
    endfunction

    function automatic t_drive_cmd advance_controller(input logic start, input longint meas,
                                                      input longint head);
        longint     err, der, total, pwr, lim, slew, corr, left, right;
        t_drive_cmd cmd;
        if (start) begin
            integ_acc = 0;
            last_err  = 0;
            power     = 0;
        end
        err = sat_q(longint'(set_point) - meas);
        if (abs_q(err) < longint'(band)) begin
            integ_acc = sat_q(integ_acc + err);
        end else begin
            integ_acc = 0;
        end
        if (mode_sel == MODE_DRIVE &&
            ((err > 0 && last_err < 0) || (err < 0 && last_err > 0))) begin
            integ_acc = 0;
        end
        der   = sat_q(err - last_err);
        total = sat_q(gain_mul(err, kp) + gain_mul(integ_acc, ki) + gain_mul(der, kd));
        pwr   = power;
        slew  = longint'(slew_lim);
        if (total > pwr + slew) begin
            pwr = pwr + slew;
        end else if (total < pwr - slew) begin
            pwr = pwr - slew;
        end else begin
            pwr = total;
        end
        pwr = sat_q(pwr);
        lim = longint'(speed_lim);
        if (pwr > lim) begin
            pwr = lim;
        end
        if (pwr < -lim) begin
            pwr = -lim;
        end
        power = pwr;
        if (mode_sel == MODE_DRIVE) begin
            corr  = (-head * 5) / 2;
            left  = sat_q(pwr + corr);
            right = sat_q(pwr - corr);
        end else begin
            left  = pwr;
            right = sat_q(-pwr);
        end
        cmd.left    = 32'(left);
        cmd.right   = 32'(right);
        cmd.settled = (abs_q(err) < longint'(SETTLE_ERR)) && (abs_q(der) < longint'(SETTLE_DER));
        last_err    = err;
        return cmd;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_drive_cmd want, got;
        if (!i_rst_n) begin
            set_point = '0;
            kp        = RST_PROP_GAIN;
            ki        = RST_INTEG_GAIN;
            kd        = RST_DERIV_GAIN;
            slew_lim  = RST_SLEW_STEP;
            speed_lim = RST_MAX_SPEED;
            band      = RST_INTEG_BAND;
            mode_sel  = MODE_DRIVE;
            integ_acc = 0;
            last_err  = 0;
            power     = 0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TARGET:     set_point = i_cfg_data;
                    REG_PROP_GAIN:  kp        = i_cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN: ki        = i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN: kd        = i_cfg_data[GAIN_W-1:0];
                    REG_SLEW_STEP:  slew_lim  = i_cfg_data[GAIN_W-1:0];
                    REG_MAX_SPEED:  speed_lim = i_cfg_data[GAIN_W-1:0];
                    REG_INTEG_BAND: band      = i_cfg_data[GAIN_W-1:0];
                    REG_MODE:       mode_sel  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready) begin
                got.left    = i_cmd_data[31:0];
                got.right   = i_cmd_data[63:32];
                got.settled = i_cmd_user[0];
                o_cmd_count++;
                if (got.settled) begin
                    o_settled_count++;
                end
                if (expected_cmds.size() == 0) begin
                    note_failure($sformatf({"Command %0d arrived with none expected: ",
                                            "left %h right %h settled %0d"},
                                           o_cmd_count, got.left, got.right, got.settled));
                end else begin
                    want = expected_cmds.pop_front();
                    if (want.left !== got.left || want.right !== got.right ||
                        want.settled !== got.settled) begin
                        note_failure($sformatf({"Command %0d mismatch: expected left %h right %h ",
                                                "settled %0d, got left %h right %h settled %0d"},
                                               o_cmd_count, want.left, want.right, want.settled,
                                               got.left, got.right, got.settled));
                    end
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                expected_cmds.push_back(advance_controller(i_tick_user[0],
                                                           longint'($signed(i_tick_data[31:0])),
                                                           longint'($signed(i_tick_data[63:32]))));
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

FILE: tb/tb_pid_slew_drive_controller.sv
// Testbench top for the slew-limited PID drive controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_pid_slew_drive_controller;

    import psdc_pkg::*;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [IDX_W-1:0]  cfg_addr   = '0;
    logic [VAL_W-1:0]  cfg_data   = '0;
    logic              tick_valid = 1'b0;
    logic              tick_ready;
    logic [63:0]       tick_data  = '0;
    logic [0:0]        tick_user  = '0;
    logic              cmd_valid;
    logic              cmd_ready  = 1'b0;
    logic [63:0]       cmd_data;
    logic [0:0]        cmd_user;

    int                fail_count, pending, cmd_count, settled_count;
    int                burst_left     = 0;
    int                ticks_sent     = 0;
    int                settings_count = 0;
    longint            cur_target     = 0;
    logic [4:0]        rcv_phase      = '0;
    logic [31:0]       rcv_pattern    = '1;

    pid_slew_drive_controller dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data),
        .s_axis_tvalid  (tick_valid),
        .s_axis_tready  (tick_ready),
        .s_axis_tdata   (tick_data),
        .s_axis_tuser   (tick_user),
        .m_axis_tvalid  (cmd_valid),
        .m_axis_tready  (cmd_ready),
        .m_axis_tdata   (cmd_data),
        .m_axis_tuser   (cmd_user)
    );

    drive_cmd_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_tick_valid    (tick_valid),
        .i_tick_ready    (tick_ready),
        .i_tick_data     (tick_data),
        .i_tick_user     (tick_user),
        .i_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .i_cmd_data      (cmd_data),
        .i_cmd_user      (cmd_user),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_cmd_count     (cmd_count),
        .o_settled_count (settled_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver walks bit by bit through a 32-bit ready pattern and picks a fresh one on each wrap.
    always @(posedge clk) begin
        if (rcv_phase == 5'd0) begin
            case ($urandom_range(0, 3))
                0:       rcv_pattern = '1;
                1:       rcv_pattern = $urandom();
                2:       rcv_pattern = $urandom() | $urandom();
                default: rcv_pattern = 32'h0F0F_00FF;
            endcase
        end
        cmd_ready <= rcv_pattern[rcv_phase];
        rcv_phase = rcv_phase + 5'd1;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] tgt, kp, ki, kd, slew, spd, band,
                              input logic [31:0] mode_val);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_SLEW_STEP, slew);
        write_reg(REG_MAX_SPEED, spd);
        write_reg(REG_INTEG_BAND, band);
        write_reg(REG_MODE, mode_val);
        cur_target = longint'($signed(tgt));
        settings_count++;
    endtask

    // Presents one tick and returns at the edge where its transfer happened.
    task automatic send_tick(input logic start, input logic [31:0] meas, input logic [31:0] head);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick_valid <= 1'b1;
        tick_data  <= {head, meas};
        tick_user  <= start;
        @(posedge clk);
        while (!tick_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic drain();
        tick_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain(input int unsigned hi);
        logic [31:0] g;
        case ($urandom_range(0, 9))
            0:       g = '0;
            1:       g = 32'h7FFF_FFFF;
            default: g = $urandom_range(0, hi);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rand_heading();
        int h;
        if ($urandom_range(0, 7) == 0) begin
            h = int'($urandom());
        end else begin
            h = int'($urandom_range(0, 1310720)) - 655360;
        end
        return h;
    endfunction

    // A move starts the controller and then sends measurements that close in on the target,
    // with an occasional wild tick thrown in.
    task automatic run_move(input int len);
        longint err;
        int     span;
        int     k;
        case ($urandom_range(0, 3))
            0:       err = longint'($urandom_range(0, 1048576)) - 524288;
            1:       err = longint'($urandom_range(0, 26214400)) - 13107200;
            2:       err = longint'($signed($urandom()));
            default: err = 0;
        endcase
        span = ($urandom_range(0, 1) == 1) ? 4000 : 200;
        for (k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 11) == 0) begin
                send_tick(1'($urandom_range(0, 1)), $urandom(), $urandom());
            end else begin
                send_tick(k == 0, 32'(cur_target - err), rand_heading());
            end
            err = (err * 3) / 4 + longint'($urandom_range(0, 2 * span)) - span;
        end
    endtask

    task automatic random_setting();
        logic [31:0] tgt;
        if ($urandom_range(0, 4) == 0) begin
            tgt = $urandom();
        end else begin
            tgt = int'($urandom_range(0, 13107200)) - 13107200 / 2;
        end
        set_config(tgt, pick_gain(20 << 16), pick_gain(1 << 16), pick_gain(8 << 16),
                   pick_gain(20 << 16), pick_gain(127 << 16), pick_gain(16 << 16), $urandom());
    endtask

    initial begin
        int p;
        int goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: start, field extremes, a sign flip of the error, settling.
        send_tick(1'b1, 32'h0000_0000, 32'h0000_0000);
        send_tick(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tick(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_tick(1'b0, 32'hFFFF_0000, 32'h0000_0000);
        send_tick(1'b0, 32'h0001_0000, 32'hFFFF_FFFF);
        send_tick(1'b0, 32'h0000_4000, 32'h0000_0000);
        send_tick(1'b0, 32'h0000_4000, 32'h0000_0000);
        send_tick(1'b1, 32'h0000_2000, 32'h0010_0000);
        drain();

        // Largest gains and limits with a zero slew step; the mode value has only bit 0 clear.
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        send_tick(1'b1, 32'h8000_0000, 32'h0000_0000);
        send_tick(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
        send_tick(1'b0, 32'h0000_0000, 32'h8000_0000);
        send_tick(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // Turn mode with a zero speed limit and a zero integration band.
        set_config(32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF,
                   32'h0, 32'h0, 32'h0000_0003);
        send_tick(1'b1, 32'h7FFF_FFFF, 32'h0000_04D2);
        send_tick(1'b0, 32'h0000_0000, 32'h0000_0000);
        send_tick(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // In turn mode an error sign change keeps the integral.
        set_config(32'h0, 32'h0006_0000, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h0004_0000, 32'h0000_0001);
        send_tick(1'b1, 32'h0001_0000, 32'h0000_0000);
        send_tick(1'b0, 32'hFFFF_0000, 32'h0000_0000);
        send_tick(1'b0, 32'h0000_8000, 32'h0000_0000);
        send_tick(1'b0, 32'h0000_0000, 32'h0000_0000);
        drain();

        // Drive mode with no speed: only the heading correction reaches the outputs.
        write_reg(REG_MODE, {31'd0, MODE_DRIVE});
        write_reg(REG_MAX_SPEED, 32'h0);
        settings_count++;
        send_tick(1'b0, 32'h0001_0000, 32'h0001_0000);
        send_tick(1'b0, 32'h0000_0000, 32'h8000_0000);
        drain();

        for (p = 0; p < 5; p++) begin
            random_setting();
            goal = ticks_sent + 80;
            while (ticks_sent < goal) begin
                run_move($urandom_range(6, 24));
                if ($urandom_range(0, 9) == 0) begin
                    drain();
                end
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d ticks under %0d register settings; %0d commands checked, %0d settled.",
                 ticks_sent, settings_count, cmd_count, settled_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run stopped by the time limit with %0d commands outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/psdc_pkg.sv
rtl/pid_slew_drive_controller.sv
tb/drive_cmd_checker.sv
tb/tb_pid_slew_drive_controller.sv
